[rtl/vzc_pkg.sv]
package vzc_pkg;

   localparam int unsigned GROUP_BITS = 7;
   localparam logic [2:0]  LAST_GROUP = 3'd4;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_VALUE   = 2'd1,
      KIND_CORRUPT = 2'd2
   } kind_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] encode_value;
      logic [7:0]  byte_in;
      logic        source_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  out_byte;
      logic [31:0] out_value;
      logic        run_last;
   } rsp_type;

   // One queued job: a value to serialise into bytes, a decoded value or an error.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;
   } work_type;

endpackage

[rtl/varint_zigzag_codec.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_type: opcode, value, byte, source flag
// rsp_      out        rsp_valid/rsp_stall  rsp_type: kind, byte, value, run flag
// csr_      in         csr_valid/csr_ready  signed_mode bit
//
// A decode byte is taken by the front unit alone; an encode value yields one byte per cycle
// from the back unit while rsp_stall is low, so it occupies that unit for one byte per 7-bit
// group, 1 to 5 bytes. Input and output are decoupled by a QUEUE_DEPTH entry job queue;
// req_stall rises only while that queue is full.
// Reset is synchronous and clears the decoder state, the queue and the output valid flag.
module varint_zigzag_codec
   import vzc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic     signed_mode_ff;
   logic     signed_mode_in;
   logic     work_push;
   work_type work_data;
   logic     queue_full;
   logic     queue_pop;
   logic     head_valid;
   work_type head_data;

   assign csr_ready      = 1'b1;
   assign signed_mode_in = (csr_valid && csr_ready) ? csr_data : signed_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   vzc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .signed_mode (signed_mode_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .work_push   (work_push),
      .work_data   (work_data)
   );

   vzc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (work_push),
      .push_data  (work_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   vzc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // A transfer into a full queue would lose a job.
   assert property (@(posedge clock) disable iff (reset) !(work_push && queue_full))
      else $error("job pushed into a full queue");

   // The queue is never popped while it is empty.
   assert property (@(posedge clock) disable iff (reset) queue_pop |-> head_valid)
      else $error("queue popped while empty");

   // Encoded bytes carry the continuation bit exactly when more bytes follow.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.result_kind == KIND_BYTE)
      |-> (rsp_payload.out_byte[7] == !rsp_payload.run_last))
      else $error("continuation bit disagrees with run_last");

   // Decoded values and errors always end their run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.result_kind != KIND_BYTE) |-> rsp_payload.run_last)
      else $error("decode result without run_last");
`endif

endmodule

[rtl/vzc_front.sv]
module vzc_front
   import vzc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     signed_mode,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   input  logic     queue_full,
   output logic     work_push,
   output work_type work_data
);

   logic [31:0] accumulator_ff;
   logic [31:0] accumulator_in;
   logic [2:0]  group_count_ff;
   logic [2:0]  group_count_in;
   logic        accept;
   logic [4:0]  shift_amount;
   logic [31:0] merged;
   logic [31:0] mapped;
   logic [31:0] unmapped;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign shift_amount = 5'(group_count_ff) * 5'(GROUP_BITS);
   assign merged       = accumulator_ff | (32'(req_payload.byte_in[6:0]) << shift_amount);

   assign mapped   = {req_payload.encode_value[30:0], 1'b0}
                     ^ {32{req_payload.encode_value[31]}};
   assign unmapped = {1'b0, merged[31:1]} ^ {32{merged[0]}};

   always_comb begin
      accumulator_in = accumulator_ff;
      group_count_in = group_count_ff;
      work_push      = 1'b0;
      work_data.kind = KIND_BYTE;
      work_data.data = '0;
      if (accept) begin
         if (req_payload.opcode == OP_ENCODE) begin
            work_push      = 1'b1;
            work_data.kind = KIND_BYTE;
            work_data.data = signed_mode ? mapped : req_payload.encode_value;
         end else if (!req_payload.byte_in[7]) begin
            work_push      = 1'b1;
            work_data.kind = KIND_VALUE;
            work_data.data = signed_mode ? unmapped : merged;
            accumulator_in = '0;
            group_count_in = '0;
         end else if (group_count_ff == LAST_GROUP || req_payload.source_last) begin
            // A fifth continuation byte, or a stream that ends mid-value.
            work_push      = 1'b1;
            work_data.kind = KIND_CORRUPT;
            accumulator_in = '0;
            group_count_in = '0;
         end else begin
            accumulator_in = merged;
            group_count_in = group_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accumulator_ff <= '0;
         group_count_ff <= '0;
      end else begin
         accumulator_ff <= accumulator_in;
         group_count_ff <= group_count_in;
      end
   end

endmodule

[rtl/vzc_queue.sv]
module vzc_queue
   import vzc_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output work_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type             mem [DEPTH];
   logic     [PTR_W-1:0] wr_ptr_ff;
   logic     [PTR_W-1:0] wr_ptr_in;
   logic     [PTR_W-1:0] rd_ptr_ff;
   logic     [PTR_W-1:0] rd_ptr_in;
   logic     [CNT_W-1:0] count_ff;
   logic     [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/vzc_back.sv]
module vzc_back
   import vzc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  work_type head_data,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   logic     cur_valid_ff;
   logic     cur_valid_in;
   work_type cur_ff;
   work_type cur_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     out_free;
   logic     emit;
   logic     more;
   logic     cur_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;
   assign more     = (cur_ff.kind == KIND_BYTE) && (cur_ff.data[31:GROUP_BITS] != '0);
   assign cur_done = emit && !more;
   assign pop      = head_valid && (!cur_valid_ff || cur_done);

   always_comb begin
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_in.result_kind = cur_ff.kind;
         rsp_in.out_byte    = '0;
         rsp_in.out_value   = '0;
         rsp_in.run_last    = !more;
         unique case (cur_ff.kind)
            KIND_BYTE:    rsp_in.out_byte  = {more, cur_ff.data[6:0]};
            KIND_VALUE:   rsp_in.out_value = cur_ff.data;
            KIND_CORRUPT: rsp_in.out_value = '0;
            default:      rsp_in.out_value = '0;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = head_data;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         // Drop the group just sent; the next one moves to the bottom.
         cur_in.data = cur_ff.data >> GROUP_BITS;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[dv/varint_zigzag_codec_test.sv]
`timescale 1ns / 100ps

module varint_zigzag_codec_test;
   import vzc_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned PHASE_ITEMS    = 70;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid   = 1'b0;
   logic    csr_ready;
   logic    csr_data    = 1'b0;

   // Decoder state and register copy held by the testbench.
   logic [31:0] dec_accum  = '0;
   logic [2:0]  dec_groups = '0;
   logic        zigzag_on  = 1'b0;

   rsp_type     due_results[$];
   int unsigned mismatches  = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left  = 0;

   varint_zigzag_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Works out the results that one accepted item must produce.
   function automatic void predict_codec(input req_type item);
      logic [31:0] v;
      logic [31:0] grp;
      logic        more;
      rsp_type     res;
      if (item.opcode == OP_ENCODE) begin
         v = item.encode_value;
         if (zigzag_on) v = {v[30:0], 1'b0} ^ {32{v[31]}};
         do begin
            more = (v > 32'h7F);
            res = '0;
            res.result_kind = KIND_BYTE;
            res.out_byte = {more, v[6:0]};
            res.run_last = !more;
            due_results.push_back(res);
            v = v >> GROUP_BITS;
         end while (more);
      end else begin
         // Data bits shifted beyond bit 31 in the fifth group are lost here.
         grp = {25'd0, item.byte_in[6:0]};
         dec_accum = dec_accum | (grp << (dec_groups * GROUP_BITS));
         res = '0;
         res.run_last = 1'b1;
         if (!item.byte_in[7]) begin
            v = dec_accum;
            if (zigzag_on) v = {1'b0, v[31:1]} ^ {32{v[0]}};
            res.result_kind = KIND_VALUE;
            res.out_value = v;
            due_results.push_back(res);
            dec_accum = '0;
            dec_groups = '0;
         end else begin
            dec_groups = dec_groups + 3'd1;
            if (dec_groups > LAST_GROUP || item.source_last) begin
               res.result_kind = KIND_CORRUPT;
               due_results.push_back(res);
               dec_accum = '0;
               dec_groups = '0;
            end
         end
      end
   endfunction

   function automatic req_type enc(input logic [31:0] v);
      req_type r;
      r.opcode = OP_ENCODE;
      r.encode_value = v;
      r.byte_in = 8'($urandom);
      r.source_last = 1'($urandom);
      return r;
   endfunction

   function automatic req_type dec(input logic [7:0] b, input logic src_last);
      req_type r;
      r.opcode = OP_DECODE;
      r.encode_value = $urandom;
      r.byte_in = b;
      r.source_last = src_last;
      return r;
   endfunction

   // Random value of random bit length, sometimes inverted to give small negatives.
   function automatic logic [31:0] rand_value();
      int unsigned w;
      logic [31:0] v;
      w = $urandom_range(0, 32);
      v = $urandom;
      if (w < 32) v = v & ((32'd1 << w) - 32'd1);
      if ($urandom_range(0, 3) == 0) v = ~v;
      return v;
   endfunction

   task automatic send_item(input req_type item);
      int unsigned r;
      int unsigned gap;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predict_codec(item);
      r = $urandom_range(0, 99);
      if (r < 50) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      // A continuation byte has no result but may still be in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_signed_mode(input logic on);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_data <= on;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      zigzag_on = on;
   endtask

   task automatic test_encode_widths();
      send_item(enc(32'h0000_0000));
      send_item(enc(32'h0000_007F));
      send_item(enc(32'h0000_0080));
      send_item(enc(32'h0FFF_FFFF));
      send_item(enc(32'h1000_0000));
      send_item(enc(32'hFFFF_FFFF));
   endtask

   task automatic test_decode_streams();
      // Five bytes whose last group overflows bit 31.
      repeat (4) send_item(dec(8'hFF, 1'b0));
      send_item(dec(8'h7F, 1'b0));
      // A fifth continuation byte is corrupt.
      repeat (5) send_item(dec(8'h80, 1'b0));
      // Continuation byte flagged as the end of the source.
      send_item(dec(8'h81, 1'b1));
      // The source flag is ignored on a terminating byte.
      send_item(dec(8'h05, 1'b1));
      // An encode in the middle of a decode leaves the partial value alone.
      send_item(dec(8'h85, 1'b0));
      send_item(enc(32'd300));
      send_item(dec(8'h01, 1'b0));
   endtask

   task automatic test_signed_mapping();
      write_signed_mode(1'b1);
      send_item(enc(32'hFFFF_FFFF));
      send_item(enc(32'h8000_0000));
      send_item(enc(32'h7FFF_FFFF));
      send_item(dec(8'h01, 1'b0));
   endtask

   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned n;
      int unsigned r;
      int unsigned len;
      logic [7:0]  b;
      logic        sl;
      for (phase = 0; phase < 4; phase++) begin
         write_signed_mode(phase[0]);
         n = 0;
         while (n < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               send_item(enc(rand_value()));
               n++;
            end else if (r < 88) begin
               // Well-formed varint with random groups; now and then cut short.
               len = $urandom_range(1, 5);
               for (int unsigned i = 0; i < len; i++) begin
                  b = {i != len - 1, 7'($urandom)};
                  if (i == len - 1) sl = 1'($urandom);
                  else sl = ($urandom_range(0, 19) == 0);
                  send_item(dec(b, sl));
                  n++;
               end
            end else begin
               send_item(dec(8'($urandom), 1'($urandom)));
               n++;
            end
            if (phase == 1 && n == PHASE_ITEMS / 2) wait_until_drained();
         end
      end
   endtask

   // Result side: random stall pattern, checking and the watchdog count.
   always @(posedge clock) begin : rsp_side
      int unsigned r;
      rsp_type     exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result: kind %0d byte %h value %h last %0d",
                     $time, rsp_payload.result_kind, rsp_payload.out_byte,
                     rsp_payload.out_value, rsp_payload.run_last);
            mismatches++;
         end else begin
            exp = due_results.pop_front();
            if (rsp_payload.result_kind !== exp.result_kind) begin
               $display("%0t: result_kind expected %0d actual %0d",
                        $time, exp.result_kind, rsp_payload.result_kind);
               mismatches++;
            end
            if (rsp_payload.out_byte !== exp.out_byte) begin
               $display("%0t: out_byte expected %h actual %h",
                        $time, exp.out_byte, rsp_payload.out_byte);
               mismatches++;
            end
            if (rsp_payload.out_value !== exp.out_value) begin
               $display("%0t: out_value expected %h actual %h",
                        $time, exp.out_value, rsp_payload.out_value);
               mismatches++;
            end
            if (rsp_payload.run_last !== exp.run_last) begin
               $display("%0t: run_last expected %0d actual %0d",
                        $time, exp.run_last, rsp_payload.run_last);
               mismatches++;
            end
         end
      end

      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;

      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(40, 80);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(0, 6);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(8, 30);
         end
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("varint_zigzag_codec: mismatch");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_encode_widths();
      test_decode_streams();
      test_signed_mapping();
      test_random_traffic();
      wait_until_drained();
      if (mismatches == 0) begin
         $display("varint_zigzag_codec: match");
      end else begin
         $display("varint_zigzag_codec: mismatch");
      end
      $finish;
   end

endmodule
